// File: hdl/fcca_pkg.sv
package fcca_pkg;

    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 16;
    localparam int CFG_W    = 13;

    localparam logic [OPCODE_W-1:0] OP_WRITE  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_START  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_EXTEND = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_END    = 3'd4;

    localparam logic [VALUE_W-1:0] MEDIA_WORD   = 16'hFFF8;
    localparam logic [VALUE_W-1:0] END_OF_CHAIN = 16'hFFFF;
    localparam logic [VALUE_W-1:0] FREE_ENTRY   = 16'h0000;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 13'd4096;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_FREE = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  entry_index;
        logic [VALUE_W-1:0]  entry_value;
    } t_cmd;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic               status;
    } t_result;

endpackage

// File: hdl/fcca_ram.sv
module fcca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/fat16_cluster_chain_allocator_unit.sv
// Write, end chain, unknown commands and reads outside the table set their result at the
// transfer; an in-table read passes through the read state first. Start chain writes
// entry 0, then entry 1, then scans; extend chain scans at once. The scan reads one table
// entry per cycle from the single read port of the table memory. The next command is taken
// at the edge that ends the result cycle; the receiver cannot stall. Reset is synchronous,
// active low: it clears the current cluster, sets the search limit to 4096.
module fat16_cluster_chain_allocator_unit #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  fcca_pkg::t_cmd            i_cmd,
    output logic                      o_done,
    output fcca_pkg::t_result         o_result,
    input  logic                      i_cfg_we,
    input  logic [fcca_pkg::CFG_W-1:0] i_cfg_wdata
);

    // Address width of the table and width of the scan pointer, which must reach
    // TABLE_ENTRIES itself. Limit comparisons run in the wider of the pointer and
    // the configuration register.
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int PW = AW + 1;
    localparam int CW = (PW > fcca_pkg::CFG_W) ? PW : fcca_pkg::CFG_W;
    localparam int VW = fcca_pkg::VALUE_W;
    localparam logic [CW-1:0] TABLE_LIMIT = CW'(TABLE_ENTRIES);

    // The controller walks a small one-hot sequence. A scan keeps one read in
    // flight: while the entry read last cycle is checked, the next one is issued.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_START1 = 4'b0100,
        S_SEARCH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [fcca_pkg::CFG_W-1:0] r_entries_in_use;
    logic [AW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_ptr, n_ptr;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_paddr, n_paddr;
    logic          r_ext, n_ext;
    logic          r_done, n_done;
    fcca_pkg::t_result r_result, n_result;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [fcca_pkg::VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]                mem_raddr;
    logic [fcca_pkg::VALUE_W-1:0] mem_rdata;

    logic          accept;
    logic          idx_ok;
    logic [AW-1:0] idx_addr;
    logic [CW-1:0] limit;
    logic [CW-1:0] eiu_ext;
    logic          ptr_in_range;
    logic          hit;

    fcca_ram #(
        .WIDTH(fcca_pkg::VALUE_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_busy   = (r_state != S_IDLE);
    assign accept   = i_start && (r_state == S_IDLE);
    assign idx_ok   = (32'(i_cmd.entry_index) < TABLE_ENTRIES);
    assign idx_addr = AW'(i_cmd.entry_index);

    // The search covers indices below the smaller of entries_in_use and the table size.
    assign eiu_ext      = CW'(r_entries_in_use);
    assign limit        = (eiu_ext < TABLE_LIMIT) ? eiu_ext : TABLE_LIMIT;
    assign ptr_in_range = (CW'(r_ptr) < limit);
    assign hit          = r_pend && (mem_rdata == fcca_pkg::FREE_ENTRY);

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_ptr     = r_ptr;
        n_pend    = r_pend;
        n_paddr   = r_paddr;
        n_ext     = r_ext;
        n_done    = 1'b0;
        n_result  = '{result_value: fcca_pkg::FREE_ENTRY, status: fcca_pkg::STATUS_OK};
        mem_we    = 1'b0;
        mem_waddr = r_cur;
        mem_wdata = fcca_pkg::END_OF_CHAIN;
        mem_raddr = r_ptr[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.opcode)
                        fcca_pkg::OP_WRITE: begin
                            mem_we    = idx_ok;
                            mem_waddr = idx_addr;
                            mem_wdata = i_cmd.entry_value;
                            n_done    = 1'b1;
                        end
                        fcca_pkg::OP_READ: begin
                            mem_raddr = idx_addr;
                            if (idx_ok) begin
                                n_state = S_READ;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        fcca_pkg::OP_START: begin
                            // Entry 0 gets the media word now, entry 1 in the next cycle.
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = fcca_pkg::MEDIA_WORD;
                            n_ptr     = PW'(2);
                            n_pend    = 1'b0;
                            n_ext     = 1'b0;
                            n_state   = S_START1;
                        end
                        fcca_pkg::OP_EXTEND: begin
                            n_ptr   = {1'b0, r_cur} + PW'(1);
                            n_pend  = 1'b0;
                            n_ext   = 1'b1;
                            n_state = S_SEARCH;
                        end
                        fcca_pkg::OP_END: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_cur;
                            mem_wdata = fcca_pkg::END_OF_CHAIN;
                            n_done    = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_done                = 1'b1;
                n_result.result_value = mem_rdata;
                n_state               = S_IDLE;
            end
            S_START1: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(1);
                mem_wdata = fcca_pkg::END_OF_CHAIN;
                n_state   = S_SEARCH;
            end
            S_SEARCH: begin
                if (hit) begin
                    // Extend links the old tail to the free entry; both commands make
                    // the free entry the new tail.
                    mem_we                = r_ext;
                    mem_waddr             = r_cur;
                    mem_wdata             = VW'(r_paddr);
                    n_cur                 = r_paddr;
                    n_done                = 1'b1;
                    n_result.result_value = VW'(r_paddr);
                    n_pend                = 1'b0;
                    n_state               = S_IDLE;
                end else if (ptr_in_range) begin
                    mem_raddr = r_ptr[AW-1:0];
                    n_paddr   = r_ptr[AW-1:0];
                    n_ptr     = r_ptr + PW'(1);
                    n_pend    = 1'b1;
                end else begin
                    // The last entry read, if any, was checked in this cycle and is in use.
                    n_pend          = 1'b0;
                    n_done          = 1'b1;
                    n_result.status = fcca_pkg::STATUS_NO_FREE;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_cur            <= '0;
            r_pend           <= 1'b0;
            r_done           <= 1'b0;
            r_entries_in_use <= fcca_pkg::ENTRIES_RESET;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_pend  <= n_pend;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_entries_in_use <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_paddr  <= n_paddr;
        r_ext    <= n_ext;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: sim/testbench.sv
module testbench;

    localparam int TBL_ENTRIES  = 4096;
    // Only this low window of the table is loaded; every search and every random read stays in it.
    localparam int FILL_ENTRIES = 48;
    localparam int OP_W         = fcca_pkg::OPCODE_W;
    localparam int IDX_W        = fcca_pkg::INDEX_W;
    localparam int VAL_W        = fcca_pkg::VALUE_W;
    localparam int CFG_BITS     = fcca_pkg::CFG_W;

    // A directed row either transfers one command or rewrites the search limit.
    // Its expectation is typed into the row only where it is obvious from the
    // table contents set up just before; otherwise the predictor supplies it.
    typedef enum logic {ROW_CMD, ROW_CFG} t_row_kind;
    typedef enum logic {FROM_MODEL, TYPED_IN} t_expect_src;

    typedef struct {
        t_row_kind          kind;
        fcca_pkg::t_cmd     cmd;
        logic [CFG_BITS-1:0] cfg_value;
        t_expect_src        src;
        fcca_pkg::t_result  want;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    fcca_pkg::t_cmd      i_cmd;
    logic                o_done;
    fcca_pkg::t_result   o_result;
    logic                i_cfg_we;
    logic [CFG_BITS-1:0] i_cfg_wdata;

    // Mirror of the allocation table, the chain tail and the search limit.
    logic [VAL_W-1:0]    fat_mirror [TBL_ENTRIES];
    logic [IDX_W-1:0]    chain_tail;
    int                  entries_cfg;

    fcca_pkg::t_result   pending_results [$];
    t_dir_row            directed_rows [$];
    int                  fail_count = 0;
    int                  sender_idle_pct = 0;

    fat16_cluster_chain_allocator_unit #(
        .TABLE_ENTRIES(TBL_ENTRIES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Lowest free entry at or above from_idx and below the search limit, or -1.
    // A limit above the table size is clamped to the table size.
    function automatic int find_free_entry(input int from_idx);
        int lim;
        lim = (entries_cfg > TBL_ENTRIES) ? TBL_ENTRIES : entries_cfg;
        for (int i = from_idx; i < lim; i++) begin
            if (fat_mirror[i] == fcca_pkg::FREE_ENTRY) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one command to the mirror and returns the result it must produce.
    function automatic fcca_pkg::t_result compute_alloc_result(input fcca_pkg::t_cmd c);
        fcca_pkg::t_result r;
        int                hit;
        r = '0;
        r.status = fcca_pkg::STATUS_OK;
        case (c.opcode)
            fcca_pkg::OP_WRITE: begin
                fat_mirror[c.entry_index] = c.entry_value;
            end
            fcca_pkg::OP_READ: begin
                r.result_value = fat_mirror[c.entry_index];
            end
            fcca_pkg::OP_START: begin
                // The reserved words go in even when the search then fails.
                fat_mirror[0] = fcca_pkg::MEDIA_WORD;
                fat_mirror[1] = fcca_pkg::END_OF_CHAIN;
                hit = find_free_entry(2);
                if (hit >= 0) begin
                    chain_tail = IDX_W'(hit);
                    r.result_value = VAL_W'(hit);
                end else begin
                    r.status = fcca_pkg::STATUS_NO_FREE;
                end
            end
            fcca_pkg::OP_EXTEND: begin
                hit = find_free_entry(int'(chain_tail) + 1);
                if (hit >= 0) begin
                    fat_mirror[chain_tail] = VAL_W'(hit);
                    chain_tail = IDX_W'(hit);
                    r.result_value = VAL_W'(hit);
                end else begin
                    r.status = fcca_pkg::STATUS_NO_FREE;
                end
            end
            fcca_pkg::OP_END: begin
                fat_mirror[chain_tail] = fcca_pkg::END_OF_CHAIN;
            end
            default: begin
                // Unknown commands leave everything alone and report zero.
            end
        endcase
        return r;
    endfunction

    // Random command of the given opcode. The index lands anywhere in the loaded
    // window, among the lowest entries, or just above the chain tail where extends
    // look, clipped to the window. Writes clear an entry a quarter of the time so
    // that free entries keep appearing.
    function automatic fcca_pkg::t_cmd random_cmd(input logic [OP_W-1:0] op);
        fcca_pkg::t_cmd c;
        int             idx;
        c.opcode = op;
        case ($urandom_range(2))
            0: idx = int'($urandom_range(FILL_ENTRIES - 1));
            1: idx = int'($urandom_range(7));
            default: idx = int'(chain_tail) + int'($urandom_range(15));
        endcase
        if (idx > FILL_ENTRIES - 1) begin
            idx = FILL_ENTRIES - 1;
        end
        c.entry_index = IDX_W'(idx);
        c.entry_value = ($urandom_range(3) == 0) ? fcca_pkg::FREE_ENTRY : VAL_W'($urandom);
        return c;
    endfunction

    function automatic void add_cmd_row(input logic [OP_W-1:0] op,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [VAL_W-1:0] val,
                                        input t_expect_src src,
                                        input logic [VAL_W-1:0] want_value,
                                        input logic want_status);
        t_dir_row row;
        row.kind = ROW_CMD;
        row.cmd.opcode = op;
        row.cmd.entry_index = idx;
        row.cmd.entry_value = val;
        row.cfg_value = '0;
        row.src = src;
        row.want.result_value = want_value;
        row.want.status = want_status;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg_row(input logic [CFG_BITS-1:0] v);
        t_dir_row row;
        row.kind = ROW_CFG;
        row.cmd = '0;
        row.cfg_value = v;
        row.src = FROM_MODEL;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    // Presents one command and holds it until the block takes it. The block
    // samples start and busy at the rising edge, so busy is read right after
    // that edge, before the block updates it. The expectation is queued at the
    // edge of the transfer; the mirror is updated even for typed-in rows.
    task automatic transfer_cmd(input fcca_pkg::t_cmd c, input t_expect_src src,
                                input fcca_pkg::t_result want);
        fcca_pkg::t_result predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start = 1'b1;
        i_cmd   = c;
        do @(posedge i_clk); while (o_busy);
        predicted = compute_alloc_result(c);
        pending_results.push_back((src == TYPED_IN) ? want : predicted);
    endtask

    // The search limit is rewritten only once the block has delivered every
    // outstanding result; every command gives exactly one result, so the block
    // is then idle.
    task automatic set_entries_in_use(input logic [CFG_BITS-1:0] v);
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        entries_cfg = int'(v);
    endtask

    // Mostly well-formed chains (start, a few extends, usually an end), with
    // stray reads, writes, unknown commands and unfinished chains mixed in.
    task automatic run_random_items(input int n_items);
        int sent;
        int links;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 7) begin
                transfer_cmd(random_cmd(fcca_pkg::OP_START), FROM_MODEL, '0);
                sent++;
                links = $urandom_range(1, 5);
                repeat (links) begin
                    if ($urandom_range(4) == 0) begin
                        transfer_cmd(random_cmd(OP_W'($urandom_range(7))), FROM_MODEL, '0);
                        sent++;
                    end
                    transfer_cmd(random_cmd(fcca_pkg::OP_EXTEND), FROM_MODEL, '0);
                    sent++;
                end
                if ($urandom_range(5) != 0) begin
                    transfer_cmd(random_cmd(fcca_pkg::OP_END), FROM_MODEL, '0);
                    sent++;
                end
            end else begin
                transfer_cmd(random_cmd(OP_W'($urandom_range(7))), FROM_MODEL, '0);
                sent++;
            end
        end
    endtask

    // Every strobed result is matched against the oldest expectation. The
    // number of reports is capped so a badly broken block cannot flood the log.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 200) begin
                    $display("%0t: unexpected result value %h status %b",
                             $time, o_result.result_value, o_result.status);
                end
            end else begin
                if (o_result.result_value !== pending_results[0].result_value) begin
                    fail_count++;
                    if (fail_count <= 200) begin
                        $display("%0t: result_value expected %h got %h", $time,
                                 pending_results[0].result_value, o_result.result_value);
                    end
                end
                if (o_result.status !== pending_results[0].status) begin
                    fail_count++;
                    if (fail_count <= 200) begin
                        $display("%0t: status expected %b got %b", $time,
                                 pending_results[0].status, o_result.status);
                    end
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // Hard stop in case the block hangs or drops a transfer.
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        fcca_pkg::t_cmd fill_cmd;

        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_cmd       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        entries_cfg = int'(fcca_pkg::ENTRIES_RESET);
        chain_tail  = '0;

        // Directed rows, meant to run right after the window has been loaded.
        // Entries 2 and 3 are set so that the first start lands on 3.
        add_cmd_row(fcca_pkg::OP_WRITE, 12'd0, 16'hFFFF, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_WRITE, 12'hFFF, fcca_pkg::FREE_ENTRY, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_READ, 12'hFFF, 16'hFFFF, TYPED_IN, fcca_pkg::FREE_ENTRY,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_WRITE, 12'd2, 16'h1234, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_WRITE, 12'd3, fcca_pkg::FREE_ENTRY, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_OK);
        // The top of the loaded window is freed so that every search below stops in it.
        add_cmd_row(fcca_pkg::OP_WRITE, IDX_W'(FILL_ENTRIES - 1), fcca_pkg::FREE_ENTRY,
                    TYPED_IN, 16'h0000, fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_READ, 12'd2, 16'h0000, TYPED_IN, 16'h1234,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_START, 12'd0, 16'h0000, TYPED_IN, 16'd3,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_READ, 12'd0, 16'h0000, TYPED_IN, fcca_pkg::MEDIA_WORD,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_READ, 12'd1, 16'h0000, TYPED_IN, fcca_pkg::END_OF_CHAIN,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_EXTEND, 12'd0, 16'h0000, FROM_MODEL, 16'h0000,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_END, 12'd0, 16'h0000, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_OK);
        // Unknown commands with extreme operands must do nothing at all.
        add_cmd_row(3'd5, 12'hFFF, 16'hFFFF, TYPED_IN, 16'h0000, fcca_pkg::STATUS_OK);
        add_cmd_row(3'd6, 12'h000, 16'h0000, TYPED_IN, 16'h0000, fcca_pkg::STATUS_OK);
        add_cmd_row(3'd7, 12'hAAA, 16'h5555, TYPED_IN, 16'h0000, fcca_pkg::STATUS_OK);
        // With a limit of 3 only entry 2 is searched, and it is in use.
        add_cfg_row(13'd3);
        add_cmd_row(fcca_pkg::OP_WRITE, 12'd2, 16'h0001, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_START, 12'd0, 16'h0000, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_NO_FREE);
        // A limit of 2 or less leaves nothing to search, even with entry 2 free.
        add_cfg_row(13'd2);
        add_cmd_row(fcca_pkg::OP_WRITE, 12'd2, fcca_pkg::FREE_ENTRY, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_START, 12'd0, 16'h0000, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_NO_FREE);
        add_cfg_row(13'd0);
        add_cmd_row(fcca_pkg::OP_EXTEND, 12'd0, 16'h0000, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_NO_FREE);
        // Limit 3 again: start takes entry 2, and the extend then runs off the top.
        add_cfg_row(13'd3);
        add_cmd_row(fcca_pkg::OP_START, 12'd0, 16'h0000, TYPED_IN, 16'd2,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_EXTEND, 12'd0, 16'h0000, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_NO_FREE);
        add_cmd_row(fcca_pkg::OP_END, 12'd0, 16'h0000, TYPED_IN, 16'h0000,
                    fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_READ, 12'd2, 16'h0000, TYPED_IN, fcca_pkg::END_OF_CHAIN,
                    fcca_pkg::STATUS_OK);
        // A limit above the table size is clamped to the table size; the freed top
        // of the window keeps the search inside the loaded entries.
        add_cfg_row(13'h1FFF);
        add_cmd_row(fcca_pkg::OP_WRITE, IDX_W'(FILL_ENTRIES - 1), fcca_pkg::FREE_ENTRY,
                    TYPED_IN, 16'h0000, fcca_pkg::STATUS_OK);
        add_cmd_row(fcca_pkg::OP_EXTEND, 12'd0, 16'h0000, FROM_MODEL, 16'h0000,
                    fcca_pkg::STATUS_OK);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The table comes out of reset undefined, so the low window is loaded
        // first; about one entry in eight is left free. Reads stay on written entries
        // and searches stop inside the window, so nothing touches an entry never written.
        for (int i = 0; i < FILL_ENTRIES; i++) begin
            fill_cmd.opcode      = fcca_pkg::OP_WRITE;
            fill_cmd.entry_index = IDX_W'(i);
            fill_cmd.entry_value = ($urandom_range(7) == 0) ? fcca_pkg::FREE_ENTRY
                                                             : VAL_W'($urandom);
            transfer_cmd(fill_cmd, FROM_MODEL, '0);
        end

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                set_entries_in_use(directed_rows[i].cfg_value);
            end else begin
                transfer_cmd(directed_rows[i].cmd, directed_rows[i].src, directed_rows[i].want);
            end
        end

        // Random phases: back to back, a sparse sender, back to back again
        // (the receiver cannot hold results off), and a lightly gapped sender.
        // Each phase starts from its own search limit inside the window.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct = 0;
                    set_entries_in_use(CFG_BITS'(FILL_ENTRIES));
                end
                1: begin
                    sender_idle_pct = 85;
                    set_entries_in_use(CFG_BITS'($urandom_range(3, 24)));
                end
                2: begin
                    sender_idle_pct = 0;
                    set_entries_in_use(CFG_BITS'($urandom_range(3, FILL_ENTRIES)));
                end
                default: begin
                    sender_idle_pct = 22;
                    set_entries_in_use(CFG_BITS'($urandom_range(FILL_ENTRIES)));
                end
            endcase
            run_random_items(16);
        end

        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // Any stray extra result is caught by the checker during this wait.
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/fcca_pkg.sv
hdl/fcca_ram.sv
hdl/fat16_cluster_chain_allocator_unit.sv
sim/testbench.sv
